>>> hw/rtl/nist_pkg.sv
package nist_pkg;

  localparam int MAX_LEVEL   = 64;
  localparam int NUMBER_BITS = 64;
  localparam int VALUE_W     = 64;
  localparam int LEVEL_W     = $clog2(MAX_LEVEL);
  localparam int LEVEL_CMP_W = 9;
  localparam int PROD_W      = NUMBER_BITS + 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_STRING = 3'd2,
    MODE_WORD   = 3'd3,
    MODE_TERM   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_LIST_OPEN    = 3'd0,
    EV_ITEM_END     = 3'd1,
    EV_STRING_BYTE  = 3'd2,
    EV_WORD_BYTE    = 3'd3,
    EV_STRING_START = 3'd4,
    EV_ERROR        = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_STRING = 2'd1,
    KIND_WORD   = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OVERFLOW  = 3'd0,
    ERR_TOO_DEEP  = 3'd1,
    ERR_BAD_START = 3'd2,
    ERR_NO_TERM   = 3'd3,
    ERR_TOP_LIST  = 3'd4
  } err_t;

  typedef struct packed {
    mode_t                  mode;
    logic [LEVEL_W-1:0]     open_lists;
    logic [NUMBER_BITS-1:0] number_accum;
    logic [NUMBER_BITS-1:0] string_remaining;
    kind_t                  pending_kind;
    logic                   error_latched;
  } state_t;

  typedef struct packed {
    event_t             ev;
    kind_t              ended_kind;
    logic [VALUE_W-1:0] value;
    logic [7:0]         data_byte;
    logic [LEVEL_W-1:0] depth;
    logic               at_top;
    err_t               error_code;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

>>> hw/rtl/nist_if.sv
interface nist_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink   (input valid, input byte_req, output ready);
endinterface

interface nist_event_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   event_res;
  logic [1:0]                   ended_kind;
  logic [nist_pkg::VALUE_W-1:0] value;
  logic [7:0]                   data_byte;
  logic [nist_pkg::LEVEL_W-1:0] depth;
  logic                         at_top;
  logic [2:0]                   error_code;

  modport source (output valid, output event_res, output ended_kind, output value,
                  output data_byte, output depth, output at_top, output error_code,
                  input ready);
  modport sink   (input valid, input event_res, input ended_kind, input value,
                  input data_byte, input depth, input at_top, input error_code,
                  output ready);
endinterface

>>> hw/rtl/nist_step.sv
module nist_step (
  input  nist_pkg::state_t  cur,
  input  logic [7:0]        data_in,
  input  logic              require_top_list,
  output nist_pkg::state_t  nxt,
  output logic              has_result,
  output nist_pkg::result_t res
);

  logic                            c_ws;
  logic                            c_digit;
  logic                            c_alpha;
  logic [3:0]                      digit;
  logic [nist_pkg::PROD_W-1:0]     prod;
  logic                            overflow;
  logic                            too_deep;
  logic                            do_fail;
  nist_pkg::err_t                  fail_code;
  logic                            do_finish;
  nist_pkg::kind_t                 fin_kind;
  logic [nist_pkg::VALUE_W-1:0]    fin_val;
  logic                            top;
  logic [nist_pkg::NUMBER_BITS-1:0] remaining_dec;

  assign c_ws    = nist_pkg::is_ws(data_in);
  assign c_digit = nist_pkg::is_digit(data_in);
  assign c_alpha = nist_pkg::is_alpha(data_in);
  assign digit   = data_in[3:0];

  // accum * 10 + digit, upper bits flag overflow
  assign prod = nist_pkg::PROD_W'({cur.number_accum, 3'b000})
              + nist_pkg::PROD_W'({cur.number_accum, 1'b0})
              + nist_pkg::PROD_W'(digit);
  assign overflow = |prod[nist_pkg::PROD_W-1:nist_pkg::NUMBER_BITS];

  assign too_deep = (nist_pkg::LEVEL_CMP_W'(cur.open_lists) + nist_pkg::LEVEL_CMP_W'(1))
                    >= nist_pkg::LEVEL_CMP_W'(nist_pkg::MAX_LEVEL);

  assign remaining_dec = cur.string_remaining - nist_pkg::NUMBER_BITS'(1);
  assign top = (cur.open_lists == '0);

  always_comb begin
    nxt        = cur;
    has_result = 1'b0;
    res        = '0;
    do_fail    = 1'b0;
    fail_code  = nist_pkg::ERR_OVERFLOW;
    do_finish  = 1'b0;
    fin_kind   = nist_pkg::KIND_NUMBER;
    fin_val    = '0;

    if (!cur.error_latched) begin
      unique case (cur.mode)
        nist_pkg::MODE_WAIT: begin
          if (c_ws) begin
            has_result = 1'b0;
          end else if (data_in == nist_pkg::CH_CLOSE && cur.open_lists != '0) begin
            nxt.open_lists   = cur.open_lists - nist_pkg::LEVEL_W'(1);
            nxt.pending_kind = nist_pkg::KIND_LIST;
            nxt.mode         = nist_pkg::MODE_TERM;
          end else if (too_deep) begin
            do_fail   = 1'b1;
            fail_code = nist_pkg::ERR_TOO_DEEP;
          end else if (c_digit) begin
            nxt.number_accum = nist_pkg::NUMBER_BITS'(digit);
            nxt.mode         = nist_pkg::MODE_NUMBER;
          end else if (c_alpha) begin
            nxt.mode      = nist_pkg::MODE_WORD;
            has_result    = 1'b1;
            res.ev        = nist_pkg::EV_WORD_BYTE;
            res.data_byte = data_in;
          end else if (data_in == nist_pkg::CH_OPEN) begin
            nxt.open_lists = cur.open_lists + nist_pkg::LEVEL_W'(1);
            has_result     = 1'b1;
            res.ev         = nist_pkg::EV_LIST_OPEN;
          end else begin
            do_fail   = 1'b1;
            fail_code = nist_pkg::ERR_BAD_START;
          end
        end
        nist_pkg::MODE_NUMBER: begin
          if (c_digit) begin
            if (overflow) begin
              do_fail   = 1'b1;
              fail_code = nist_pkg::ERR_OVERFLOW;
            end else begin
              nxt.number_accum = prod[nist_pkg::NUMBER_BITS-1:0];
            end
          end else if (data_in == nist_pkg::CH_COLON) begin
            nxt.string_remaining = cur.number_accum;
            nxt.pending_kind     = nist_pkg::KIND_STRING;
            nxt.mode = (cur.number_accum != '0) ? nist_pkg::MODE_STRING
                                                : nist_pkg::MODE_TERM;
            has_result = 1'b1;
            res.ev     = nist_pkg::EV_STRING_START;
            res.value  = nist_pkg::VALUE_W'(cur.number_accum);
          end else if (c_ws) begin
            do_finish = 1'b1;
            fin_kind  = nist_pkg::KIND_NUMBER;
            fin_val   = nist_pkg::VALUE_W'(cur.number_accum);
          end else begin
            do_fail   = 1'b1;
            fail_code = nist_pkg::ERR_NO_TERM;
          end
        end
        nist_pkg::MODE_STRING: begin
          nxt.string_remaining = remaining_dec;
          if (remaining_dec == '0) begin
            nxt.pending_kind = nist_pkg::KIND_STRING;
            nxt.mode         = nist_pkg::MODE_TERM;
          end
          has_result    = 1'b1;
          res.ev        = nist_pkg::EV_STRING_BYTE;
          res.data_byte = data_in;
        end
        nist_pkg::MODE_WORD: begin
          if (c_alpha || c_digit || data_in == nist_pkg::CH_DASH) begin
            has_result    = 1'b1;
            res.ev        = nist_pkg::EV_WORD_BYTE;
            res.data_byte = data_in;
          end else if (c_ws) begin
            do_finish = 1'b1;
            fin_kind  = nist_pkg::KIND_WORD;
          end else begin
            do_fail   = 1'b1;
            fail_code = nist_pkg::ERR_NO_TERM;
          end
        end
        nist_pkg::MODE_TERM: begin
          if (c_ws) begin
            do_finish = 1'b1;
            fin_kind  = cur.pending_kind;
          end else begin
            do_fail   = 1'b1;
            fail_code = nist_pkg::ERR_NO_TERM;
          end
        end
        default: begin
          nxt.mode = nist_pkg::MODE_WAIT;
        end
      endcase

      // a top-level item that is not a list may be refused
      if (do_finish) begin
        nxt.mode = nist_pkg::MODE_WAIT;
        if (top && fin_kind != nist_pkg::KIND_LIST && require_top_list) begin
          do_fail   = 1'b1;
          fail_code = nist_pkg::ERR_TOP_LIST;
        end else begin
          has_result     = 1'b1;
          res.ev         = nist_pkg::EV_ITEM_END;
          res.ended_kind = fin_kind;
          res.value      = fin_val;
          res.at_top     = top;
        end
      end

      if (do_fail) begin
        nxt.error_latched = 1'b1;
        nxt.mode          = nist_pkg::MODE_WAIT;
        has_result        = 1'b1;
        res               = '0;
        res.ev            = nist_pkg::EV_ERROR;
        res.error_code    = fail_code;
      end
    end

    res.depth = has_result ? nxt.open_lists : '0;
  end

endmodule

>>> hw/rtl/nested_item_stream_tokenizer.sv
// an accepted byte waits in the byte register; its event is written to the event register when the byte advances
// throughput: one byte per cycle, sustained while the event side keeps taking
// bytes that raise no event pass even while an earlier event waits at the output
// one byte register, one event register; all parsing sits between the two
// reset (rst, synchronous, active high): parser waits for an item start, no lists
// open, no error, both registers empty, require_top_list set to 1
module nested_item_stream_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  nist_byte_if.sink           byte_in,
  nist_event_if.source        event_out
);

  // configuration
  logic require_top_list;

  // byte register
  logic       in_valid;
  logic [7:0] in_byte;

  // event register
  logic              out_valid;
  nist_pkg::result_t out_res;

  // parser state
  nist_pkg::state_t  state;
  nist_pkg::state_t  state_next;
  nist_pkg::result_t step_res;
  logic              step_has;

  logic advance;

  nist_step u_step (
    .cur              (state),
    .data_in          (in_byte),
    .require_top_list (require_top_list),
    .nxt              (state_next),
    .has_result       (step_has),
    .res              (step_res)
  );

  // the held byte moves on when it raises no event or the event slot frees up
  assign advance       = in_valid && (!step_has || !out_valid || event_out.ready);
  assign byte_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      require_top_list <= 1'b1;
    end else if (cfg_wr_en) begin
      require_top_list <= cfg_wr_data;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.byte_req;
    end
  end

  // parser state advances once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode             <= nist_pkg::MODE_WAIT;
      state.open_lists       <= '0;
      state.number_accum     <= '0;
      state.string_remaining <= '0;
      state.pending_kind     <= nist_pkg::KIND_NUMBER;
      state.error_latched    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_has) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_has) begin
      out_res <= step_res;
    end
  end

  assign event_out.valid      = out_valid;
  assign event_out.event_res  = out_res.ev;
  assign event_out.ended_kind = out_res.ended_kind;
  assign event_out.value      = out_res.value;
  assign event_out.data_byte  = out_res.data_byte;
  assign event_out.depth      = out_res.depth;
  assign event_out.at_top     = out_res.at_top;
  assign event_out.error_code = out_res.error_code;

  // an error event leaves the parser latched
  a_error_latches: assert property (@(posedge clk) disable iff (rst)
    (advance && step_has && step_res.ev == nist_pkg::EV_ERROR) |=> state.error_latched)
    else $error("error event did not latch the parser");

  // nothing more comes out once latched
  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    state.error_latched |-> !(advance && step_has))
    else $error("event produced after an error");

  // list open raises the nesting count by one
  a_open_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && step_has && step_res.ev == nist_pkg::EV_LIST_OPEN)
    |=> state.open_lists == $past(state.open_lists) + nist_pkg::LEVEL_W'(1))
    else $error("list open did not raise the nesting count");

  // a held byte is never dropped while it waits for the event slot
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte)))
    else $error("stalled byte lost");

endmodule
